@@ rtl/atp_pkg.sv @@
// ----------------------------------------------------------------------------
// atp_pkg
// Shared widths, fixed-point constants and sideband type for the
// polynomial atan2 pipeline.
// ----------------------------------------------------------------------------
package atp_pkg;

  localparam int DEF_INPUT_BITS      = 16;
  localparam int DEF_ANGLE_FRAC_BITS = 13;

  // ratio is unsigned Q1.18, range [0, 1.0] inclusive
  localparam int RATIO_FRAC = 18;
  localparam int RATIO_W    = RATIO_FRAC + 1;
  localparam int SQ_W       = 2 * RATIO_W;

  // polynomial accumulator: signed, 32 fraction bits, |acc| stays below 2^32
  localparam int ACC_FRAC = 32;
  localparam int ACC_W    = 34;
  localparam int PROD_W   = ACC_W + RATIO_W + 1;

  // fold arithmetic reaches pi * 2^32 (35 bits signed)
  localparam int FOLD_W = 36;

  localparam int NUM_COEF = 6;

  // Horner coefficients, highest power first, value * 2^32 rounded
  localparam logic signed [ACC_W-1:0] POLY_COEF [NUM_COEF] = '{
    -34'sd57898178,
     34'sd246863184,
    -34'sd520717845,
     34'sd840249900,
    -34'sd1430200904,
     34'sd4294948527
  };

  localparam logic signed [FOLD_W-1:0] PI_HALF_FIX = 36'sd6746518853;
  localparam logic signed [FOLD_W-1:0] PI_FIX      = 36'sd13493037706;

  typedef struct packed {
    logic swap;   // |y| > |x|
    logic x_neg;
    logic y_neg;
    logic zero;   // both inputs zero
  } side_t;

endpackage

@@ rtl/atp_prep.sv @@
// ----------------------------------------------------------------------------
// atp_prep
// Input stage: magnitudes, larger/smaller selection and octant flags.
// ----------------------------------------------------------------------------
module atp_prep #(
  parameter int INPUT_BITS = atp_pkg::DEF_INPUT_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [INPUT_BITS-1:0] in_y,
  input  logic signed [INPUT_BITS-1:0] in_x,
  output logic                         out_valid,
  output logic        [INPUT_BITS-1:0] out_mx,
  output logic        [INPUT_BITS-1:0] out_mn,
  output atp_pkg::side_t               out_side
);
  import atp_pkg::*;

  logic [INPUT_BITS-1:0] ay;
  logic [INPUT_BITS-1:0] ax;
  logic                  y_big;

  // two's complement negate of the most negative code gives the right magnitude
  assign ay    = in_y[INPUT_BITS-1] ? $unsigned(-in_y) : $unsigned(in_y);
  assign ax    = in_x[INPUT_BITS-1] ? $unsigned(-in_x) : $unsigned(in_x);
  assign y_big = ay > ax;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_mx         <= y_big ? ay : ax;
      out_mn         <= y_big ? ax : ay;
      out_side.swap  <= y_big;
      out_side.x_neg <= in_x[INPUT_BITS-1];
      out_side.y_neg <= in_y[INPUT_BITS-1];
      out_side.zero  <= (ay == '0) && (ax == '0);
    end
  end

endmodule

@@ rtl/atp_div.sv @@
// ----------------------------------------------------------------------------
// atp_div
// Pipelined restoring divider: ratio = floor(mn * 2^18 / mx), one
// quotient bit per stage, integer bit first.
// ----------------------------------------------------------------------------
module atp_div #(
  parameter int MAG_BITS = atp_pkg::DEF_INPUT_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [MAG_BITS-1:0]          in_mx,
  input  logic [MAG_BITS-1:0]          in_mn,
  input  atp_pkg::side_t               in_side,
  output logic                         out_valid,
  output logic [atp_pkg::RATIO_W-1:0]  out_ratio,
  output atp_pkg::side_t               out_side
);
  import atp_pkg::*;

  logic                vld  [RATIO_W];
  logic [MAG_BITS-1:0] rem  [RATIO_W];
  logic [MAG_BITS-1:0] dvs  [RATIO_W];
  logic [RATIO_W-1:0]  quo  [RATIO_W];
  side_t               side [RATIO_W];

  for (genvar s = 0; s < RATIO_W; s++) begin : g_stage
    logic                v_in;
    logic [MAG_BITS:0]   trial;
    logic [MAG_BITS-1:0] d_in;
    logic [RATIO_W-1:0]  q_in;
    side_t               sd_in;
    logic                take;

    if (s == 0) begin : g_first
      assign v_in  = in_valid;
      assign trial = {1'b0, in_mn};
      assign d_in  = in_mx;
      assign q_in  = '0;
      assign sd_in = in_side;
    end else begin : g_next
      assign v_in  = vld[s-1];
      assign trial = {rem[s-1], 1'b0};
      assign d_in  = dvs[s-1];
      assign q_in  = quo[s-1];
      assign sd_in = side[s-1];
    end

    assign take = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]  <= take ? MAG_BITS'(trial - {1'b0, d_in}) : MAG_BITS'(trial);
        dvs[s]  <= d_in;
        quo[s]  <= {q_in[RATIO_W-2:0], take};
        side[s] <= sd_in;
      end
    end
  end

  assign out_valid = vld[RATIO_W-1];
  assign out_ratio = quo[RATIO_W-1];
  assign out_side  = side[RATIO_W-1];

endmodule

@@ rtl/atp_poly.sv @@
// ----------------------------------------------------------------------------
// atp_poly
// Odd degree-11 minimax polynomial in Horner form on r^2, then times r.
// Each multiply and each round/add gets its own register stage.
// ----------------------------------------------------------------------------
module atp_poly (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic        [atp_pkg::RATIO_W-1:0] in_ratio,
  input  atp_pkg::side_t                     in_side,
  output logic                               out_valid,
  output logic signed [atp_pkg::ACC_W-1:0]   out_poly,
  output atp_pkg::side_t                     out_side
);
  import atp_pkg::*;

  localparam int NSTEP = NUM_COEF - 1;

  // round half up, then drop RATIO_FRAC bits
  function automatic logic signed [ACC_W-1:0] round_prod(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] t;
    t = p + (PROD_W'(1) << (RATIO_FRAC - 1));
    return ACC_W'(t >>> RATIO_FRAC);
  endfunction

  // square stage
  logic               va;
  logic [SQ_W-1:0]    sq_a;
  logic [RATIO_W-1:0] r_a;
  side_t              sd_a;

  // r^2 stage
  logic               vb;
  logic [RATIO_W-1:0] r2_b;
  logic [RATIO_W-1:0] r_b;
  side_t              sd_b;

  // Horner multiply / add stages
  logic                     v_m   [NSTEP];
  logic signed [PROD_W-1:0] prd_m [NSTEP];
  logic [RATIO_W-1:0]       r2_m  [NSTEP];
  logic [RATIO_W-1:0]       r_m   [NSTEP];
  side_t                    sd_m  [NSTEP];

  logic                     v_h   [NSTEP];
  logic signed [ACC_W-1:0]  acc_h [NSTEP];
  logic [RATIO_W-1:0]       r2_h  [NSTEP-1];
  logic [RATIO_W-1:0]       r_h   [NSTEP];
  side_t                    sd_h  [NSTEP];

  // final multiply by r
  logic                     vf;
  logic signed [PROD_W-1:0] prd_f;
  side_t                    sd_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vf        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= in_valid;
      vb        <= va;
      vf        <= v_h[NSTEP-1];
      out_valid <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_a     <= SQ_W'(in_ratio) * SQ_W'(in_ratio);
      r_a      <= in_ratio;
      sd_a     <= in_side;
      r2_b     <= RATIO_W'((sq_a + (SQ_W'(1) << (RATIO_FRAC - 1))) >> RATIO_FRAC);
      r_b      <= r_a;
      sd_b     <= sd_a;
      prd_f    <= PROD_W'(acc_h[NSTEP-1])
                  * PROD_W'($signed({1'b0, r_h[NSTEP-1]}));
      sd_f     <= sd_h[NSTEP-1];
      out_poly <= round_prod(prd_f);
      out_side <= sd_f;
    end
  end

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    logic                    v_in;
    logic signed [ACC_W-1:0] acc_in;
    logic [RATIO_W-1:0]      r2_in;
    logic [RATIO_W-1:0]      r_in;
    side_t                   sd_in;

    if (j == 0) begin : g_first
      assign v_in   = vb;
      assign acc_in = POLY_COEF[0];
      assign r2_in  = r2_b;
      assign r_in   = r_b;
      assign sd_in  = sd_b;
    end else begin : g_next
      assign v_in   = v_h[j-1];
      assign acc_in = acc_h[j-1];
      assign r2_in  = r2_h[j-1];
      assign r_in   = r_h[j-1];
      assign sd_in  = sd_h[j-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_m[j] <= 1'b0;
        v_h[j] <= 1'b0;
      end else if (en) begin
        v_m[j] <= v_in;
        v_h[j] <= v_m[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        prd_m[j] <= PROD_W'(acc_in) * PROD_W'($signed({1'b0, r2_in}));
        r2_m[j]  <= r2_in;
        r_m[j]   <= r_in;
        sd_m[j]  <= sd_in;
        acc_h[j] <= round_prod(prd_m[j]) + POLY_COEF[j+1];
        r_h[j]   <= r_m[j];
        sd_h[j]  <= sd_m[j];
      end
    end

    if (j < NSTEP - 1) begin : g_r2
      always_ff @(posedge clk) begin
        if (en) begin
          r2_h[j] <= r2_m[j];
        end
      end
    end
  end

endmodule

@@ rtl/atp_fold.sv @@
// ----------------------------------------------------------------------------
// atp_fold
// Octant/quadrant fold of the first-octant angle and reduction to the
// output fraction width.
// ----------------------------------------------------------------------------
module atp_fold #(
  parameter int ANGLE_FRAC_BITS = atp_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [atp_pkg::ACC_W-1:0]  in_poly,
  input  atp_pkg::side_t                    in_side,
  output logic                              out_valid,
  output logic signed [ANGLE_FRAC_BITS+2:0] out_angle,
  output logic                              out_zero
);
  import atp_pkg::*;

  localparam int ANGLE_W = ANGLE_FRAC_BITS + 3;
  localparam int SHIFT   = ACC_FRAC - ANGLE_FRAC_BITS;

  logic signed [FOLD_W-1:0] a_ext;
  logic signed [FOLD_W-1:0] a_oct;
  logic signed [FOLD_W-1:0] a_quad;
  logic signed [FOLD_W-1:0] a_sgn;
  logic signed [FOLD_W-1:0] a_rnd;

  logic                     v1;
  logic signed [FOLD_W-1:0] a1;
  logic                     yneg1;
  logic                     zero1;

  assign a_ext  = FOLD_W'(in_poly);
  assign a_oct  = in_side.swap  ? PI_HALF_FIX - a_ext : a_ext;
  assign a_quad = in_side.x_neg ? PI_FIX - a_oct : a_oct;

  assign a_sgn  = yneg1 ? -a1 : a1;
  assign a_rnd  = (a_sgn + (FOLD_W'(1) << (SHIFT - 1))) >>> SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1        <= a_quad;
      yneg1     <= in_side.y_neg;
      zero1     <= in_side.zero;
      out_angle <= zero1 ? '0 : ANGLE_W'(a_rnd);
      out_zero  <= zero1;
    end
  end

endmodule

@@ rtl/atan2_polynomial_approx_top.sv @@
// ----------------------------------------------------------------------------
// atan2_polynomial_approx_top
// Four-quadrant arctangent of (y, x) by ratio division, odd minimax
// polynomial and octant fold; result in radians, signed Q3.13 by default.
//
// Usage:
//   s_axis beat: tdata = {x_value, y_value}, y in the low bits.
//   m_axis beat: tdata = angle (zero padded to bytes), tuser = both_zero.
//   Both inputs zero gives angle 0 with tuser set.
//   Throughput: one beat per cycle while m_axis_tready stays high, with no gaps required.
//   Stages from input beat to output beat: 1 magnitude stage, 19
//   divider stages (one quotient bit each), 14 polynomial stages
//   (multiply and round/add per Horner step), 2 fold stages and the
//   output register.
//   The output register plus a one-beat skid stage sit after the pipeline.
//   A stalled receiver first fills the skid stage; s_axis_tready then
//   drops as soon as the skid stage holds a beat and the whole pipeline holds in place.
//   Reset (rst, synchronous) empties the pipeline and the output stage.
// ----------------------------------------------------------------------------
module atan2_polynomial_approx_top #(
  parameter int INPUT_BITS      = atp_pkg::DEF_INPUT_BITS,
  parameter int ANGLE_FRAC_BITS = atp_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // tdata: y_value, x_value
  input  logic [((2*INPUT_BITS+7)/8)*8-1:0]          s_axis_tdata,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // tdata: angle
  output logic [((ANGLE_FRAC_BITS+3+7)/8)*8-1:0]     m_axis_tdata,
  // tuser: both_zero
  output logic                                       m_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready
);
  import atp_pkg::*;

  localparam int ANGLE_W  = ANGLE_FRAC_BITS + 3;
  localparam int OUT_TD_W = ((ANGLE_W + 7) / 8) * 8;

  logic en;

  logic                         p_valid;
  logic [INPUT_BITS-1:0]        p_mx;
  logic [INPUT_BITS-1:0]        p_mn;
  side_t                        p_side;

  logic                         d_valid;
  logic [RATIO_W-1:0]           d_ratio;
  side_t                        d_side;

  logic                         q_valid;
  logic signed [ACC_W-1:0]      q_poly;
  side_t                        q_side;

  logic                         tail_valid;
  logic signed [ANGLE_W-1:0]    tail_angle;
  logic                         tail_zero;

  logic                         out_valid;
  logic signed [ANGLE_W-1:0]    out_angle;
  logic                         out_zero;
  logic                         skid_valid;
  logic signed [ANGLE_W-1:0]    skid_angle;
  logic                         skid_zero;

  // pipeline moves whenever the skid stage is free
  assign en            = !skid_valid;
  assign s_axis_tready = en;

  atp_prep #(
    .INPUT_BITS(INPUT_BITS)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_axis_tvalid),
    .in_y     ($signed(s_axis_tdata[INPUT_BITS-1:0])),
    .in_x     ($signed(s_axis_tdata[2*INPUT_BITS-1:INPUT_BITS])),
    .out_valid(p_valid),
    .out_mx   (p_mx),
    .out_mn   (p_mn),
    .out_side (p_side)
  );

  atp_div #(
    .MAG_BITS(INPUT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (p_valid),
    .in_mx    (p_mx),
    .in_mn    (p_mn),
    .in_side  (p_side),
    .out_valid(d_valid),
    .out_ratio(d_ratio),
    .out_side (d_side)
  );

  atp_poly u_poly (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d_valid),
    .in_ratio (d_ratio),
    .in_side  (d_side),
    .out_valid(q_valid),
    .out_poly (q_poly),
    .out_side (q_side)
  );

  atp_fold #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_fold (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (q_valid),
    .in_poly  (q_poly),
    .in_side  (q_side),
    .out_valid(tail_valid),
    .out_angle(tail_angle),
    .out_zero (tail_zero)
  );

  // output register with one-beat skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_axis_tready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (tail_valid) begin
      if (out_valid && !m_axis_tready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_axis_tready) begin
        out_angle <= skid_angle;
        out_zero  <= skid_zero;
      end
    end else if (tail_valid) begin
      if (out_valid && !m_axis_tready) begin
        skid_angle <= tail_angle;
        skid_zero  <= tail_zero;
      end else begin
        out_angle <= tail_angle;
        out_zero  <= tail_zero;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TD_W'($unsigned(out_angle));
  assign m_axis_tuser  = out_zero;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a beat while output register is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !m_axis_tready) |=> skid_valid)
    else $error("skid beat dropped without a receiver handshake");

  a_tail_frozen: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && tail_valid) |=> tail_valid)
    else $error("pipeline tail lost a beat during stall");

  a_zero_angle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_zero) |-> (out_angle == '0))
    else $error("both_zero result carries a nonzero angle");

endmodule
